### src/calendar_date_arithmetic_unit_macros.svh
// ----------------------------------------------------------------------------
// Calendar date arithmetic unit - assertion macros
// Shared property forms for the port checker. They expect clk and rst in scope.
// ----------------------------------------------------------------------------
`ifndef CALENDAR_DATE_ARITHMETIC_UNIT_MACROS_SVH
`define CALENDAR_DATE_ARITHMETIC_UNIT_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define CDAU_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define CDAU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/cdau_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdau_pkg
// Types, field widths and calendar tables for the date arithmetic unit.
// ----------------------------------------------------------------------------
package cdau_pkg;

  localparam int OP_BITS    = 2;
  localparam int YEAR_BITS  = 12;
  localparam int MONTH_BITS = 4;
  localparam int DAY_BITS   = 5;
  localparam int DOY_BITS   = 9;
  localparam int MP_BITS    = 4;

  // years are shifted up so every day number stays positive
  localparam int YEAR_SHIFT     = 400;
  localparam int DAYS_PER_YEAR  = 365;
  // floor(x / 100) == (x * RECIP100) >> RECIP100_SHIFT for x < 199728
  localparam int RECIP100       = 167773;
  localparam int RECIP100_BITS  = 18;
  localparam int RECIP100_SHIFT = 24;
  // March-based day of year for Jan 1 and Dec 31
  localparam int DOY_JAN1       = 306;
  localparam int DOY_DEC31      = 305;
  localparam int MP_LAST        = 11;

  typedef enum logic [OP_BITS-1:0] {
    OP_ADD  = 2'd0,
    OP_SUB  = 2'd1,
    OP_DIFF = 2'd2,
    OP_CMP  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    FSRC_FIRST  = 2'd0,
    FSRC_OTHER  = 2'd1,
    FSRC_SEARCH = 2'd2
  } fsrc_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_FA_MUL,
    S_FA_SUM,
    S_ZA,
    S_FB_MUL,
    S_FB_SUM,
    S_ZB,
    S_DIFF,
    S_ADJ,
    S_CLAMP,
    S_SRCH_MUL,
    S_SRCH_SUM,
    S_SRCH_CMP,
    S_DOY,
    S_MONTH,
    S_DATE,
    S_DONE
  } state_t;

  typedef struct packed {
    logic  load;
    logic  f_mul;
    fsrc_t f_src;
    logic  f_sum;
    logic  za_load;
    logic  zb_load;
    logic  diff_load;
    logic  adjust;
    logic  clamp;
    logic  srch_cmp;
    logic  doy_load;
    logic  month_load;
    logic  date_load;
    logic  out_load;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic srch_last;
  } stat_t;

  function automatic logic [MONTH_BITS-1:0] clamp_month(input logic [MONTH_BITS-1:0] m);
    logic [MONTH_BITS-1:0] r;
    if (m == 4'd0) begin
      r = 4'd1;
    end else if (m > 4'd12) begin
      r = 4'd12;
    end else begin
      r = m;
    end
    return r;
  endfunction

  // month 1..12 to March-based month 0..11
  function automatic logic [MP_BITS-1:0] month_to_mp(input logic [MONTH_BITS-1:0] m);
    return (m > 4'd2) ? (m - 4'd3) : (m + 4'd9);
  endfunction

  // first March-based day of year for each March-based month
  function automatic logic [DOY_BITS-1:0] mp_offset(input logic [MP_BITS-1:0] mp);
    logic [DOY_BITS-1:0] r;
    case (mp)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd92;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd153;
      4'd6:    r = 9'd184;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd245;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd306;
      4'd11:   r = 9'd337;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

### src/cdau_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdau_ctrl
// Sequencer for the date unit: steps the datapath through day-number
// conversion, adjust, year search and date rebuild, and owns the output valid.
// ----------------------------------------------------------------------------
module cdau_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  output logic            m_tvalid,
  input  logic            m_tready,
  input  cdau_pkg::stat_t stat,
  output cdau_pkg::cmd_t  cmd
);
  import cdau_pkg::*;

  state_t state, state_next;
  logic   m_tvalid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      m_tvalid <= m_tvalid_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:     if (s_tvalid) state_next = S_FA_MUL;
      S_FA_MUL:   state_next = (stat.op == OP_CMP) ? S_DONE : S_FA_SUM;
      S_FA_SUM:   state_next = S_ZA;
      S_ZA:       state_next = (stat.op == OP_DIFF) ? S_FB_MUL : S_ADJ;
      S_FB_MUL:   state_next = S_FB_SUM;
      S_FB_SUM:   state_next = S_ZB;
      S_ZB:       state_next = S_DIFF;
      S_DIFF:     state_next = S_DONE;
      S_ADJ:      state_next = S_CLAMP;
      S_CLAMP:    state_next = S_SRCH_MUL;
      S_SRCH_MUL: state_next = S_SRCH_SUM;
      S_SRCH_SUM: state_next = S_SRCH_CMP;
      S_SRCH_CMP: state_next = stat.srch_last ? S_DOY : S_SRCH_MUL;
      S_DOY:      state_next = S_MONTH;
      S_MONTH:    state_next = S_DATE;
      S_DATE:     state_next = S_DONE;
      S_DONE:     if (!m_tvalid || m_tready) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    s_tready = 1'b0;
    case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        cmd.load = s_tvalid;
      end
      S_FA_MUL: begin
        cmd.f_mul = 1'b1;
        cmd.f_src = FSRC_FIRST;
      end
      S_FB_MUL: begin
        cmd.f_mul = 1'b1;
        cmd.f_src = FSRC_OTHER;
      end
      S_SRCH_MUL: begin
        cmd.f_mul = 1'b1;
        cmd.f_src = FSRC_SEARCH;
      end
      S_FA_SUM, S_FB_SUM, S_SRCH_SUM: cmd.f_sum = 1'b1;
      S_ZA:       cmd.za_load    = 1'b1;
      S_ZB:       cmd.zb_load    = 1'b1;
      S_DIFF:     cmd.diff_load  = 1'b1;
      S_ADJ:      cmd.adjust     = 1'b1;
      S_CLAMP:    cmd.clamp      = 1'b1;
      S_SRCH_CMP: cmd.srch_cmp   = 1'b1;
      S_DOY:      cmd.doy_load   = 1'b1;
      S_MONTH:    cmd.month_load = 1'b1;
      S_DATE:     cmd.date_load  = 1'b1;
      S_DONE:     cmd.out_load   = !m_tvalid || m_tready;
      default:    cmd            = '0;
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      m_tvalid_next = 1'b1;
    end else if (m_tready) begin
      m_tvalid_next = 1'b0;
    end else begin
      m_tvalid_next = m_tvalid;
    end
  end

endmodule

### src/cdau_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdau_dp
// Datapath: operand registers, shared year-to-day-count unit F(Y), day number
// adjust and clamp, bitwise year search, month lookup and the output word.
// F(Y) = 365*Y + Y/4 - Y/100 + Y/400 counts days before March 1 of year Y.
// ----------------------------------------------------------------------------
module cdau_dp #(
  parameter  int MAX_YEAR   = 4095,
  parameter  int COUNT_BITS = 21,
  localparam int IN_W       = ((42 + COUNT_BITS + 7) / 8) * 8,
  localparam int OUT_W      = ((23 + COUNT_BITS + 7) / 8) * 8
) (
  input  logic                             clk,
  input  logic [IN_W-1:0]                  s_tdata,
  input  logic [cdau_pkg::OP_BITS-1:0]     s_tuser,
  input  cdau_pkg::cmd_t                   cmd,
  output cdau_pkg::stat_t                  stat,
  output logic [OUT_W-1:0]                 m_tdata
);
  import cdau_pkg::*;

  localparam int YW_NEED = $clog2(MAX_YEAR + YEAR_SHIFT + 1);
  localparam int YW      = (YW_NEED > YEAR_BITS + 1) ? YW_NEED : YEAR_BITS + 1;
  localparam int FW      = YW + 9;
  localparam int ZW      = ((FW > COUNT_BITS) ? FW : COUNT_BITS) + 2;
  localparam int BW      = $clog2(YW);
  localparam int PW      = YW + RECIP100_BITS;
  localparam int QW      = PW - RECIP100_SHIFT;
  localparam int DW      = COUNT_BITS - 1;
  localparam int HI_Y    = MAX_YEAR + YEAR_SHIFT;
  localparam int LO_DAY  = DAYS_PER_YEAR * YEAR_SHIFT + YEAR_SHIFT / 4 - YEAR_SHIFT / 100
                           + YEAR_SHIFT / 400 + DOY_JAN1;
  localparam int HI_DAY  = DAYS_PER_YEAR * HI_Y + HI_Y / 4 - HI_Y / 100 + HI_Y / 400
                           + DOY_DEC31;

  // input word layout
  localparam int I_FM  = YEAR_BITS;
  localparam int I_FD  = I_FM + MONTH_BITS;
  localparam int I_CNT = I_FD + DAY_BITS;
  localparam int I_OY  = I_CNT + COUNT_BITS;
  localparam int I_OM  = I_OY + YEAR_BITS;
  localparam int I_OD  = I_OM + MONTH_BITS;
  // output word layout
  localparam int O_RM   = YEAR_BITS;
  localparam int O_RD   = O_RM + MONTH_BITS;
  localparam int O_DIFF = O_RD + DAY_BITS;
  localparam int O_GT   = O_DIFF + DW;
  localparam int O_EQ   = O_GT + 1;
  localparam int O_OOR  = O_EQ + 1;

  localparam logic [YW-1:0]        MAX_YEAR_Y = YW'(MAX_YEAR);
  localparam logic [YW-1:0]        SHIFT_Y    = YW'(YEAR_SHIFT);
  localparam logic signed [ZW-1:0] LO_Z       = ZW'(LO_DAY);
  localparam logic signed [ZW-1:0] HI_Z       = ZW'(HI_DAY);
  localparam logic [DW-1:0]        DIFF_MAX   = {DW{1'b1}};

  // unpacked input word
  logic [YEAR_BITS-1:0]  in_fy, in_oy;
  logic [MONTH_BITS-1:0] in_fm, in_om;
  logic [DAY_BITS-1:0]   in_fd, in_od;
  logic [COUNT_BITS-1:0] in_cnt;
  logic                  in_fy_bad, in_oy_bad;

  // operand registers
  op_t                   op_q;
  logic [YEAR_BITS-1:0]  fy, oy;
  logic [MONTH_BITS-1:0] fm, om;
  logic [DAY_BITS-1:0]   fd, od;
  logic [COUNT_BITS-1:0] cnt;
  logic                  gt, eq, oor;

  // day-count unit
  logic [MP_BITS-1:0] fmp, omp;
  logic [YW-1:0]      yy_first, yy_other, cand, f_arg;
  logic [PW-1:0]      f_prod;
  logic [YW-1:0]      f_y;
  logic [FW-1:0]      f_p365;
  logic [QW-1:0]      f_q100;
  logic [FW-1:0]      f_val;

  // day numbers and search
  logic signed [ZW-1:0] z_calc, za, zb, z, cnt_ext, dist_raw, dist_abs, doy_full;
  logic [DOY_BITS-1:0]  z_off;
  logic [DAY_BITS-1:0]  z_day;
  logic [YW-1:0]        y_cur;
  logic [FW-1:0]        f_best;
  logic [BW-1:0]        bit_idx;

  // date rebuild
  logic [DOY_BITS-1:0]   doy;
  logic [MP_BITS-1:0]    mp, mp_n;
  logic [MONTH_BITS-1:0] mm;
  logic [YW-1:0]         ry;
  logic [MONTH_BITS-1:0] rm;
  logic [DAY_BITS-1:0]   rd;
  logic [DW-1:0]         diff;
  logic [OUT_W-1:0]      out_word;

  assign in_fy  = s_tdata[YEAR_BITS-1:0];
  assign in_fm  = s_tdata[I_FM +: MONTH_BITS];
  assign in_fd  = s_tdata[I_FD +: DAY_BITS];
  assign in_cnt = s_tdata[I_CNT +: COUNT_BITS];
  assign in_oy  = s_tdata[I_OY +: YEAR_BITS];
  assign in_om  = s_tdata[I_OM +: MONTH_BITS];
  assign in_od  = s_tdata[I_OD +: DAY_BITS];

  assign in_fy_bad = (in_fy == '0) || (YW'(in_fy) > MAX_YEAR_Y);
  assign in_oy_bad = (in_oy == '0) || (YW'(in_oy) > MAX_YEAR_Y);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q <= op_t'(s_tuser);
      fy   <= in_fy;
      fm   <= in_fm;
      fd   <= in_fd;
      cnt  <= in_cnt;
      oy   <= in_oy;
      om   <= in_om;
      od   <= in_od;
      // compare works on the raw fields, year then month then day
      gt   <= {in_fy, in_fm, in_fd} > {in_oy, in_om, in_od};
      eq   <= {in_fy, in_fm, in_fd} == {in_oy, in_om, in_od};
      if (op_t'(s_tuser) == OP_ADD || op_t'(s_tuser) == OP_SUB) begin
        oor <= in_fy_bad;
      end else begin
        oor <= in_fy_bad || in_oy_bad;
      end
    end else if (cmd.diff_load) begin
      if (dist_abs > ZW'(DIFF_MAX)) oor <= 1'b1;
    end else if (cmd.clamp) begin
      if (z < LO_Z || z > HI_Z) oor <= 1'b1;
    end
  end

  // Jan and Feb count with the previous March-based year
  assign fmp      = month_to_mp(clamp_month(fm));
  assign omp      = month_to_mp(clamp_month(om));
  assign yy_first = YW'(fy) + SHIFT_Y - YW'(fmp > 4'd9);
  assign yy_other = YW'(oy) + SHIFT_Y - YW'(omp > 4'd9);
  assign cand     = y_cur | (YW'(1) << bit_idx);

  always_comb begin
    case (cmd.f_src)
      FSRC_FIRST:  f_arg = yy_first;
      FSRC_OTHER:  f_arg = yy_other;
      FSRC_SEARCH: f_arg = cand;
      default:     f_arg = cand;
    endcase
  end

  assign f_prod = PW'(f_arg) * PW'(RECIP100);

  always_ff @(posedge clk) begin
    if (cmd.f_mul) begin
      f_y    <= f_arg;
      f_p365 <= FW'(f_arg) * FW'(DAYS_PER_YEAR);
      f_q100 <= f_prod[PW-1:RECIP100_SHIFT];
    end
    if (cmd.f_sum) begin
      f_val <= f_p365 + FW'(f_y >> 2) - FW'(f_q100) + FW'(f_q100 >> 2);
    end
  end

  assign z_off    = cmd.zb_load ? mp_offset(omp) : mp_offset(fmp);
  assign z_day    = cmd.zb_load ? od : fd;
  assign z_calc   = ZW'(f_val) + ZW'(z_off) + ZW'(z_day) - ZW'(1);
  assign cnt_ext  = ZW'($signed(cnt));
  assign dist_raw = za - zb;
  assign dist_abs = dist_raw[ZW-1] ? -dist_raw : dist_raw;
  assign doy_full = z - ZW'(f_best);

  always_ff @(posedge clk) begin
    if (cmd.za_load) za <= z_calc;
    if (cmd.zb_load) zb <= z_calc;
    if (cmd.diff_load) begin
      diff <= (dist_abs > ZW'(DIFF_MAX)) ? DIFF_MAX : dist_abs[DW-1:0];
    end
    if (cmd.adjust) begin
      z <= (op_q == OP_SUB) ? (za - cnt_ext) : (za + cnt_ext);
    end
    if (cmd.clamp) begin
      if (z < LO_Z) begin
        z <= LO_Z;
      end else if (z > HI_Z) begin
        z <= HI_Z;
      end
      y_cur   <= '0;
      f_best  <= '0;
      bit_idx <= BW'(YW - 1);
    end
    // keep the largest year whose March 1 is not past the day number
    if (cmd.srch_cmp) begin
      if (ZW'(f_val) <= z) begin
        y_cur  <= f_y;
        f_best <= f_val;
      end
      bit_idx <= bit_idx - 1'b1;
    end
    if (cmd.doy_load)   doy <= doy_full[DOY_BITS-1:0];
    if (cmd.month_load) mp  <= mp_n;
    if (cmd.date_load) begin
      ry <= y_cur - SHIFT_Y + YW'(mm <= 4'd2);
      rm <= mm;
      rd <= DAY_BITS'(doy - mp_offset(mp) + 9'd1);
    end
  end

  assign stat.op        = op_q;
  assign stat.srch_last = (bit_idx == '0);

  always_comb begin
    mp_n = '0;
    for (int k = 1; k <= MP_LAST; k++) begin
      if (doy >= mp_offset(MP_BITS'(k))) mp_n = MP_BITS'(k);
    end
  end

  assign mm = (mp < 4'd10) ? (mp + 4'd3) : (mp - 4'd9);

  always_comb begin
    out_word = '0;
    case (op_q)
      OP_ADD, OP_SUB: begin
        out_word[YEAR_BITS-1:0]      = ry[YEAR_BITS-1:0];
        out_word[O_RM +: MONTH_BITS] = rm;
        out_word[O_RD +: DAY_BITS]   = rd;
      end
      OP_DIFF: out_word[O_DIFF +: DW] = diff;
      OP_CMP: begin
        out_word[O_GT] = gt;
        out_word[O_EQ] = eq;
      end
      default: out_word = '0;
    endcase
    out_word[O_OOR] = oor;
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) m_tdata <= out_word;
  end

endmodule

### src/calendar_date_arithmetic_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// calendar_date_arithmetic_unit
// Gregorian date add/subtract days, day difference and date compare.
// ----------------------------------------------------------------------------
//  channel | direction | word
//  s_*     | in        | tuser: opcode; tdata: first date, day_count, other date
//  m_*     | out       | tdata: result date, day_difference, flags
//
//  One word at a time. Add/subtract is dominated by the bitwise year search
//  over YW = max(13, clog2(MAX_YEAR + 401)) bits (13 at default); each bit
//  steps through the shared day-count multiplier unit: multiply, sum and
//  compare.
//  A finished word waits in the output register while the next one is taken.
//  rst is synchronous and clears the sequencer and m_tvalid.
// ----------------------------------------------------------------------------
module calendar_date_arithmetic_unit #(
  parameter  int MAX_YEAR   = 4095,
  parameter  int COUNT_BITS = 21,
  localparam int IN_W       = ((42 + COUNT_BITS + 7) / 8) * 8,
  localparam int OUT_W      = ((23 + COUNT_BITS + 7) / 8) * 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  // first_year, first_month, first_day, day_count, other_year, other_month,
  // other_day
  input  logic [IN_W-1:0]              s_tdata,
  // opcode
  input  logic [cdau_pkg::OP_BITS-1:0] s_tuser,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // result_year, result_month, result_day, day_difference, is_greater,
  // is_equal, out_of_range
  output logic [OUT_W-1:0]             m_tdata
);
  import cdau_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  cdau_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  cdau_dp #(
    .MAX_YEAR   (MAX_YEAR),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk     (clk),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .cmd     (cmd),
    .stat    (stat),
    .m_tdata (m_tdata)
  );

endmodule

### src/cdau_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdau_chk
// Port checker for the date unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "calendar_date_arithmetic_unit_macros.svh"

module cdau_chk #(
  parameter  int COUNT_BITS = 21,
  localparam int OUT_W      = ((23 + COUNT_BITS + 7) / 8) * 8
) (
  input logic             clk,
  input logic             rst,
  input logic             s_tvalid,
  input logic             s_tready,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [OUT_W-1:0] m_tdata
);
  localparam int O_GT = 20 + COUNT_BITS;
  localparam int O_EQ = 21 + COUNT_BITS;

  `CDAU_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled output word changed")

  // one word in flight: no accept right after an accept
  `CDAU_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready, "input taken while busy")

  `CDAU_ASSERT_SAME(a_cmp_flags, m_tvalid, !(m_tdata[O_GT] && m_tdata[O_EQ]), "greater and equal both set")

  // a result word has month 1..12 and a non-zero day, otherwise month and day are both zero
  `CDAU_ASSERT_SAME(a_date_shape, m_tvalid, (m_tdata[15:12] == 4'd0 && m_tdata[20:16] == 5'd0) || (m_tdata[15:12] != 4'd0 && m_tdata[15:12] <= 4'd12 && m_tdata[20:16] != 5'd0), "bad result date")

endmodule

bind calendar_date_arithmetic_unit cdau_chk #(
  .COUNT_BITS (COUNT_BITS)
) u_cdau_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

### dv/cdau_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdau_checker
// Watches both stream channels of the date arithmetic unit. For each accepted
// input word it computes the expected result word and queues it. Each result
// word is compared field by field with the oldest queued one.
// ----------------------------------------------------------------------------
module cdau_checker #(
  parameter int MAX_YEAR = 4095
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  // first_year, first_month, first_day, day_count, other_year, other_month,
  // other_day
  input  logic [63:0] s_tdata,
  // opcode
  input  logic [1:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  // result_year, result_month, result_day, day_difference, is_greater,
  // is_equal, out_of_range
  input  logic [47:0] m_tdata,
  output int          mismatches,
  output int          awaiting
);
  import cdau_pkg::*;

  localparam longint ERA_DAYS = 146097;
  localparam longint DIFF_SAT = (64'd1 << 20) - 1;

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [19:0] span;
    logic        later;
    logic        same;
    logic        range_err;
  } date_word_t;

  date_word_t dates_due[$];
  date_word_t want;
  int         nbad;

  function automatic longint fold_month(input logic [3:0] m);
    if (m == 4'd0) return 1;
    if (m > 4'd12) return 12;
    return longint'(m);
  endfunction

  function automatic bit year_outside(input logic [11:0] y);
    return (y == 12'd0) || (longint'(y) > MAX_YEAR);
  endfunction

  // days since a fixed origin; years offset so the count stays positive
  function automatic longint serial_day(input longint y, input longint m, input longint d);
    longint yy, era, yoe, mp, doy, doe;
    yy  = y + YEAR_SHIFT - ((m <= 2) ? 1 : 0);
    era = yy / 400;
    yoe = yy - era * 400;
    mp  = (m > 2) ? (m - 3) : (m + 9);
    doy = (153 * mp + 2) / 5 + d - 1;
    doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
    return era * ERA_DAYS + doe;
  endfunction

  function automatic void date_of_serial(input longint z, output longint y,
                                         output longint m, output longint d);
    longint era, doe, yoe, doy, mp;
    era = z / ERA_DAYS;
    doe = z - era * ERA_DAYS;
    yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
    doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
    mp  = (5 * doy + 2) / 153;
    d   = doy - (153 * mp + 2) / 5 + 1;
    m   = (mp < 10) ? (mp + 3) : (mp - 9);
    y   = yoe + era * 400 + ((m <= 2) ? 1 : 0) - YEAR_SHIFT;
  endfunction

  function automatic date_word_t date_calc(input op_t op, input logic [63:0] w);
    date_word_t  r;
    logic [11:0] fy, oy;
    logic [3:0]  fm, om;
    logic [4:0]  fd, od;
    longint      cnt, za, zb, lo, hi, y, m, d, gap_days;
    fy  = w[11:0];
    fm  = w[15:12];
    fd  = w[20:16];
    cnt = longint'($signed(w[41:21]));
    oy  = w[53:42];
    om  = w[57:54];
    od  = w[62:58];
    r   = '0;
    case (op)
      OP_ADD, OP_SUB: begin
        lo = serial_day(1, 1, 1);
        hi = serial_day(MAX_YEAR, 12, 31);
        za = serial_day(longint'(fy), fold_month(fm), longint'(fd));
        r.range_err = year_outside(fy);
        za = (op == OP_ADD) ? za + cnt : za - cnt;
        if (za < lo) begin
          za = lo;
          r.range_err = 1'b1;
        end
        if (za > hi) begin
          za = hi;
          r.range_err = 1'b1;
        end
        date_of_serial(za, y, m, d);
        r.year  = y[11:0];
        r.month = m[3:0];
        r.day   = d[4:0];
      end
      OP_DIFF: begin
        za       = serial_day(longint'(fy), fold_month(fm), longint'(fd));
        zb       = serial_day(longint'(oy), fold_month(om), longint'(od));
        gap_days = (za > zb) ? za - zb : zb - za;
        r.range_err = year_outside(fy) || year_outside(oy);
        if (gap_days > DIFF_SAT) begin
          gap_days = DIFF_SAT;
          r.range_err = 1'b1;
        end
        r.span = gap_days[19:0];
      end
      default: begin
        // raw fields, no month folding
        if (fy != oy) r.later = fy > oy;
        else if (fm != om) r.later = fm > om;
        else r.later = fd > od;
        r.same      = (fy == oy) && (fm == om) && (fd == od);
        r.range_err = year_outside(fy) || year_outside(oy);
      end
    endcase
    return r;
  endfunction

  function automatic int field_bad(input string name, input longint exp_v,
                                   input longint act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_v, act_v);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      dates_due.delete();
      mismatches <= 0;
      awaiting   <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (dates_due.size() == 0) begin
          $display("%0t: unexpected result word, expected none actual %h", $time, m_tdata);
          mismatches <= mismatches + 1;
        end else begin
          want = dates_due.pop_front();
          nbad = field_bad("result_year", longint'(want.year), longint'(m_tdata[11:0]))
               + field_bad("result_month", longint'(want.month), longint'(m_tdata[15:12]))
               + field_bad("result_day", longint'(want.day), longint'(m_tdata[20:16]))
               + field_bad("day_difference", longint'(want.span), longint'(m_tdata[40:21]))
               + field_bad("is_greater", longint'(want.later), longint'(m_tdata[41]))
               + field_bad("is_equal", longint'(want.same), longint'(m_tdata[42]))
               + field_bad("out_of_range", longint'(want.range_err), longint'(m_tdata[43]));
          mismatches <= mismatches + nbad;
        end
      end
      if (s_tvalid && s_tready) begin
        dates_due.push_back(date_calc(op_t'(s_tuser), s_tdata));
      end
      awaiting <= dates_due.size();
    end
  end

endmodule

### dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives the date arithmetic unit with directed corner dates and then random
// words, with random gaps on the input and stalls on the output. The checker
// predicts every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb;
  import cdau_pkg::*;

  localparam int N_RANDOM = 580;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata  = '0;
  logic [1:0]  s_tuser  = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;
  int          mismatches;
  int          awaiting;
  bit          no_idle  = 1'b0;

  calendar_date_arithmetic_unit u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  cdau_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .mismatches (mismatches),
    .awaiting   (awaiting)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // valid stays up across back-to-back words; it only drops for a gap
  task automatic send_date(input op_t op, input logic [11:0] fy, input logic [3:0] fm,
                           input logic [4:0] fd, input logic [20:0] cnt,
                           input logic [11:0] oy, input logic [3:0] om,
                           input logic [4:0] od);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 10);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {1'b0, od, om, oy, cnt, fd, fm, fy};
    do @(negedge clk); while (!s_tready);
    @(posedge clk);
  endtask

  // output side stalls
  initial begin
    int hold;
    wait (!rst);
    forever begin
      hold = no_idle ? 0 : $urandom_range(0, 10);
      if (hold != 0) begin
        m_tready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(negedge clk); while (!m_tvalid);
      @(posedge clk);
    end
  end

  initial begin
    #5ms;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    op_t         op;
    logic [11:0] fy, oy;
    logic [3:0]  fm, om;
    logic [4:0]  fd, od;
    logic [20:0] cnt;
    logic [31:0] r;
    int          pick;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // leap rule across Feb, including century years
    send_date(OP_ADD, 12'd2024, 4'd2, 5'd28, 21'd1, 12'd1, 4'd1, 5'd1);
    send_date(OP_ADD, 12'd1900, 4'd2, 5'd28, 21'd1, 12'd1, 4'd1, 5'd1);
    send_date(OP_ADD, 12'd2000, 4'd2, 5'd28, 21'd1, 12'd1, 4'd1, 5'd1);
    send_date(OP_SUB, 12'd2000, 4'd3, 5'd1, 21'd1, 12'd1, 4'd1, 5'd1);
    send_date(OP_ADD, 12'd1999, 4'd12, 5'd31, 21'd1, 12'd1, 4'd1, 5'd1);
    // negative counts swap direction
    send_date(OP_ADD, 12'd2023, 4'd5, 5'd10, -21'sd10, 12'd1, 4'd1, 5'd1);
    send_date(OP_SUB, 12'd2023, 4'd5, 5'd10, -21'sd40, 12'd1, 4'd1, 5'd1);
    // saturation at both ends of the year range
    send_date(OP_ADD, 12'd4095, 4'd12, 5'd31, 21'd1, 12'd1, 4'd1, 5'd1);
    send_date(OP_SUB, 12'd1, 4'd1, 5'd1, 21'd1, 12'd1, 4'd1, 5'd1);
    send_date(OP_ADD, 12'd2000, 4'd1, 5'd1, 21'h0FFFFF, 12'd1, 4'd1, 5'd1);
    send_date(OP_SUB, 12'd2000, 4'd1, 5'd1, 21'h100000, 12'd1, 4'd1, 5'd1);
    // bad year, folded months, day rolling
    send_date(OP_ADD, 12'd0, 4'd0, 5'd0, 21'd0, 12'd0, 4'd0, 5'd0);
    send_date(OP_ADD, 12'd2021, 4'd15, 5'd31, 21'd0, 12'd1, 4'd1, 5'd1);
    send_date(OP_ADD, 12'd2021, 4'd2, 5'd31, 21'd0, 12'd1, 4'd1, 5'd1);
    send_date(OP_ADD, 12'd2021, 4'd3, 5'd0, 21'd0, 12'd1, 4'd1, 5'd1);
    send_date(OP_SUB, 12'd4095, 4'd15, 5'd31, 21'h100000, 12'd4095, 4'd15, 5'd31);
    // difference: saturated, small, bad year, folded months
    send_date(OP_DIFF, 12'd1, 4'd1, 5'd1, 21'd0, 12'd4095, 4'd12, 5'd31);
    send_date(OP_DIFF, 12'd2000, 4'd3, 5'd1, 21'd0, 12'd2000, 4'd2, 5'd28);
    send_date(OP_DIFF, 12'd10, 4'd6, 5'd15, 21'd0, 12'd0, 4'd6, 5'd15);
    send_date(OP_DIFF, 12'd1999, 4'd13, 5'd5, 21'd0, 12'd2001, 4'd0, 5'd0);
    // compare on raw fields
    send_date(OP_CMP, 12'd2020, 4'd7, 5'd4, 21'd0, 12'd2020, 4'd7, 5'd4);
    send_date(OP_CMP, 12'd2020, 4'd7, 5'd5, 21'd0, 12'd2020, 4'd7, 5'd4);
    send_date(OP_CMP, 12'd2020, 4'd6, 5'd30, 21'd0, 12'd2020, 4'd7, 5'd1);
    send_date(OP_CMP, 12'd2020, 4'd15, 5'd1, 21'd0, 12'd2020, 4'd12, 5'd31);
    send_date(OP_CMP, 12'd4095, 4'd1, 5'd1, 21'd0, 12'd0, 4'd1, 5'd1);

    for (int n = 0; n < N_RANDOM; n++) begin
      no_idle = (n % 120) >= 90;
      pick    = $urandom_range(0, 99);
      op      = op_t'($urandom_range(0, 3));
      if (pick < 80) begin
        fy = 12'($urandom_range(1, 4095));
        fm = 4'($urandom_range(1, 12));
        fd = (pick % 5 == 0) ? 5'($urandom_range(1, 31)) : 5'($urandom_range(1, 28));
        if (pick < 45) begin
          cnt = 21'($urandom_range(0, 1000) - 500);
        end else begin
          r   = $urandom;
          cnt = r[20:0];
        end
        case (pick % 4)
          0: begin
            oy = fy;
            om = fm;
            od = fd;
          end
          1: begin
            oy = fy;
            om = 4'($urandom_range(1, 12));
            od = 5'($urandom_range(1, 28));
          end
          default: begin
            oy = 12'($urandom_range(1, 4095));
            om = 4'($urandom_range(1, 12));
            od = 5'($urandom_range(1, 31));
          end
        endcase
      end else begin
        r   = $urandom;
        fy  = r[11:0];
        fm  = r[15:12];
        fd  = r[20:16];
        oy  = r[31:20];
        r   = $urandom;
        om  = r[3:0];
        od  = r[8:4];
        cnt = r[31:11];
      end
      send_date(op, fy, fm, fd, cnt, oy, om, od);
    end
    s_tvalid <= 1'b0;
    no_idle = 1'b0;

    do @(negedge clk); while (awaiting != 0);
    repeat (60) @(posedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
